FILE: design/half_float_converter_macros.svh
// assertion macros used by the half_float_converter top module
// no dependencies
`ifndef HALF_FLOAT_CONVERTER_MACROS_SVH
`define HALF_FLOAT_CONVERTER_MACROS_SVH

// antecedent implies consequent, consequent may carry a constant delay
`define HFC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// condition must never hold
`define HFC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

FILE: design/hfc_pkg.sv
// types and constants of the binary16/binary32 converter
// no dependencies
`timescale 1ns / 1ps
package hfc_pkg;

  typedef enum logic {
    CMD_NARROW = 1'b0,
    CMD_WIDEN  = 1'b1
  } cmd_e;

  localparam logic [15:0] H_INF      = 16'h7C00;
  localparam logic [9:0]  H_QUIET    = 10'h200;
  localparam logic [7:0]  F_EXP_MAX  = 8'hFF;
  localparam logic [4:0]  H_EXP_MAX  = 5'h1F;
  localparam logic [7:0]  EXP_REBIAS = 8'd112;
  localparam int unsigned F_FRAC_W   = 23;
  localparam int unsigned H_FRAC_W   = 10;

endpackage

FILE: design/half_float_converter.sv
// half_float_converter: start reaches done through v1_q, v2_q and done_q, one beat per cycle
// throughput one conversion every cycle through a three stage pipeline
// busy_o stays low: the pipeline never stalls, the receiver cannot hold off
// rst_ni asynchronous active low clears the valid and command pipeline only
// depends on hfc_pkg, hfc_narrow, hfc_widen, half_float_converter_macros.svh
`timescale 1ns / 1ps
`include "half_float_converter_macros.svh"
module half_float_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [31:0] result_o
);

  logic              v1_q, v2_q, done_q;
  hfc_pkg::cmd_e     cmd1_q, cmd2_q, cmd3_q;
  logic [15:0]       narrow_res;
  logic [31:0]       widen_res;
  logic [31:0]       result_d, result_q;

  assign busy_o = 1'b0;

  hfc_narrow u_narrow (
    .clk_i    (clk_i),
    .value_i  (value_i),
    .result_o (narrow_res)
  );

  hfc_widen u_widen (
    .clk_i    (clk_i),
    .value_i  (value_i[15:0]),
    .result_o (widen_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
      cmd1_q <= hfc_pkg::CMD_NARROW;
      cmd2_q <= hfc_pkg::CMD_NARROW;
      cmd3_q <= hfc_pkg::CMD_NARROW;
    end else begin
      v1_q   <= start_i && !busy_o;
      v2_q   <= v1_q;
      done_q <= v2_q;
      cmd1_q <= hfc_pkg::cmd_e'(command_i);
      cmd2_q <= cmd1_q;
      cmd3_q <= cmd2_q;
    end
  end

  assign result_d = (cmd2_q == hfc_pkg::CMD_WIDEN) ? widen_res : {16'd0, narrow_res};

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `HFC_ASSERT_IMPLIES(a_start_done, clk_i, rst_ni, start_i && !busy_o, ##3 done_o, "beat lost")
  `HFC_ASSERT_IMPLIES(a_no_spurious, clk_i, rst_ni, !start_i, ##3 !done_o, "beat invented")
  `HFC_ASSERT_NEVER(a_narrow_upper, clk_i, rst_ni, done_o && (cmd3_q == hfc_pkg::CMD_NARROW) && (result_o[31:16] != 16'd0), "narrow result upper half not zero")

endmodule

FILE: design/hfc_narrow.sv
// binary32 to binary16 narrowing, two register stages and a rounding adder
// depends on hfc_pkg
`timescale 1ns / 1ps
module hfc_narrow (
  input  logic        clk_i,
  input  logic [31:0] value_i,
  output logic [15:0] result_o
);

  // stage 1: classify and rebias
  logic                                sgn_q;
  logic [hfc_pkg::F_FRAC_W-1:0]        frac_q;
  logic signed [8:0]                   e_q;
  logic                                spec_q, ovf_q, tiny_q, sub_q;
  logic signed [8:0]                   e_d;

  assign e_d = $signed({1'b0, value_i[30:23]}) - $signed({1'b0, hfc_pkg::EXP_REBIAS});

  always_ff @(posedge clk_i) begin
    sgn_q  <= value_i[31];
    frac_q <= value_i[22:0];
    e_q    <= e_d;
    spec_q <= (value_i[30:23] == hfc_pkg::F_EXP_MAX);
    ovf_q  <= (e_d >= 9'sd31);
    tiny_q <= (e_d < -9'sd10);
    sub_q  <= (e_d <= 9'sd0);
  end

  // stage 2: align and collect round and sticky bits
  logic [15:0] base_d, base_q;
  logic        rnd_d, rnd_q, stk_d, stk_q;
  logic [23:0] mant;
  logic [3:0]  nsh;
  logic [4:0]  hpos;
  logic [23:0] wide, mask;
  logic [9:0]  qv;
  logic [9:0]  nan_m;

  always_comb begin
    mant  = {1'b1, frac_q};
    nsh   = 4'(9'sd0 - e_q);
    hpos  = {1'b0, nsh} + 5'd13;
    wide  = mant >> hpos;
    mask  = (24'd1 << hpos) - 24'd1;
    qv    = mant[23:14] >> nsh;
    nan_m = (frac_q != '0) ? (frac_q[22:13] | hfc_pkg::H_QUIET) : 10'd0;
    rnd_d = 1'b0;
    stk_d = 1'b0;
    if (spec_q) begin
      base_d = {sgn_q, 15'd0} | hfc_pkg::H_INF | {6'd0, nan_m};
    end else if (ovf_q) begin
      base_d = {sgn_q, 15'd0} | hfc_pkg::H_INF;
    end else if (tiny_q) begin
      base_d = {sgn_q, 15'd0};
    end else if (sub_q) begin
      base_d = {sgn_q, 5'd0, qv};
      rnd_d  = wide[0];
      stk_d  = |(mant & mask);
    end else begin
      base_d = {sgn_q, e_q[4:0], frac_q[22:13]};
      rnd_d  = frac_q[12];
      stk_d  = |frac_q[11:0];
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    rnd_q  <= rnd_d;
    stk_q  <= stk_d;
  end

  // stage 3: round to nearest even, carry may run into the exponent
  assign result_o = base_q + {15'd0, rnd_q & (stk_q | base_q[0])};

endmodule

FILE: design/hfc_widen.sv
// binary16 to binary32 widening, two register stages and a normalising shift
// depends on hfc_pkg
`timescale 1ns / 1ps
module hfc_widen (
  input  logic        clk_i,
  input  logic [15:0] value_i,
  output logic [31:0] result_o
);

  // stage 1: split fields
  logic                         sgn1_q, sgn2_q;
  logic [4:0]                   ef1_q, ef2_q;
  logic [hfc_pkg::H_FRAC_W-1:0] m1_q, m2_q;

  always_ff @(posedge clk_i) begin
    sgn1_q <= value_i[15];
    ef1_q  <= value_i[14:10];
    m1_q   <= value_i[9:0];
  end

  // stage 2: leading one of a subnormal mantissa
  logic [3:0] lead_d, lead_q;

  always_comb begin
    lead_d = 4'd0;
    for (int i = 0; i < hfc_pkg::H_FRAC_W; i++) begin
      if (m1_q[i]) begin
        lead_d = 4'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sgn2_q <= sgn1_q;
    ef2_q  <= ef1_q;
    m2_q   <= m1_q;
    lead_q <= lead_d;
  end

  // stage 3: normalise and assemble
  logic [3:0]  sh;
  logic [10:0] mn;
  logic [7:0]  ex;

  always_comb begin
    sh = 4'd10 - lead_q;
    mn = {1'b0, m2_q} << sh;
    ex = 8'd103 + {4'd0, lead_q};
    if (ef2_q == 5'd0) begin
      if (m2_q == '0) begin
        result_o = {sgn2_q, 31'd0};
      end else begin
        result_o = {sgn2_q, ex, mn[9:0], 13'd0};
      end
    end else if (ef2_q == hfc_pkg::H_EXP_MAX) begin
      result_o = {sgn2_q, hfc_pkg::F_EXP_MAX, m2_q, 13'd0};
    end else begin
      result_o = {sgn2_q, {3'd0, ef2_q} + hfc_pkg::EXP_REBIAS, m2_q, 13'd0};
    end
  end

endmodule
